[rtl/wtti_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the wide text to integer parser.
package wtti_pkg;

   localparam int CHAR_W      = 16;
   localparam int BASE_W      = 6;
   localparam int VALUE_W     = 32;
   localparam int OFFSET_W    = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_DIGITS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_BASE  = 2'd3;

   localparam logic [VALUE_W-1:0] SIGNED_MAX   = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0] SIGNED_MIN   = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] UNSIGNED_MAX = 32'hffff_ffff;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBER_BASE = 1'b0,
      CSR_SIGNED_MODE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_ZERO_X,
      PH_DIGITS,
      PH_DONE
   } parse_phase_type;

   // Classification of one character, produced by the front end.
   typedef struct packed {
      logic              start;
      logic              blank;
      logic              plus;
      logic              minus;
      logic              zero;
      logic              letter_x;
      logic              digit_ok;
      logic [BASE_W-1:0] digit_val;
   } item_class_type;

endpackage

[rtl/wtti_front.sv]
`timescale 1ns / 1ps
// Front end: accepts characters and classifies them for the parser.
module wtti_front (
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wtti_pkg::CHAR_W-1:0]       req_wide_char,
   input  logic                              req_string_start,
   input  logic                              queue_full,
   output logic                              push,
   output wtti_pkg::item_class_type          push_item
);
   import wtti_pkg::*;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item           = '0;
      push_item.start     = req_string_start;
      push_item.blank     = (req_wide_char == 16'd32) ||
                            (req_wide_char >= 16'd9 && req_wide_char <= 16'd13);
      push_item.plus      = (req_wide_char == 16'd43);
      push_item.minus     = (req_wide_char == 16'd45);
      push_item.zero      = (req_wide_char == 16'd48);
      push_item.letter_x  = (req_wide_char == 16'd120) || (req_wide_char == 16'd88);
      push_item.digit_ok  = 1'b0;
      push_item.digit_val = '0;
      if (req_wide_char >= 16'd48 && req_wide_char <= 16'd57) begin
         push_item.digit_ok  = 1'b1;
         push_item.digit_val = BASE_W'(req_wide_char - 16'd48);
      end else if (req_wide_char >= 16'd97 && req_wide_char <= 16'd122) begin
         push_item.digit_ok  = 1'b1;
         push_item.digit_val = BASE_W'(req_wide_char - 16'd87);
      end else if (req_wide_char >= 16'd65 && req_wide_char <= 16'd90) begin
         push_item.digit_ok  = 1'b1;
         push_item.digit_val = BASE_W'(req_wide_char - 16'd55);
      end
   end

endmodule

[rtl/wtti_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified characters between front end and parser.
module wtti_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wtti_pkg::item_class_type  push_item,
   input  logic                      pop,
   output logic                      full,
   output logic                      not_empty,
   output wtti_pkg::item_class_type  head_item
);
   import wtti_pkg::*;

   item_class_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;

   assign full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue count beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule

[rtl/wtti_back.sv]
`timescale 1ns / 1ps
// Back end: parse state machine, accumulator and result register.
module wtti_back #(
   parameter longint unsigned MAX_OFFSET = 65535
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  wtti_pkg::item_class_type           item,
   output logic                               item_pop,
   input  logic [wtti_pkg::BASE_W-1:0]        number_base,
   input  logic                               signed_mode,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [wtti_pkg::VALUE_W-1:0]       rsp_parsed_value,
   output logic [wtti_pkg::OFFSET_W-1:0]      rsp_end_offset,
   output logic [wtti_pkg::STATUS_W-1:0]      rsp_parse_status
);
   import wtti_pkg::*;

   localparam int POS_W = $clog2(MAX_OFFSET + 64'd1);

   parse_phase_type        phase_ff, phase_in;
   logic [VALUE_W-1:0]     acc_ff, acc_in;
   logic                   minus_ff, minus_in;
   logic                   ovf_ff, ovf_in;
   logic                   dseen_ff, dseen_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [POS_W-1:0]       pos_ff, pos_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [STATUS_W-1:0]    status_ff, status_in;

   logic                   take;
   logic                   bad_base;
   logic                   do_finish;
   logic [POS_W-1:0]       finish_end;
   logic [VALUE_W+BASE_W-1:0] mac;
   logic [63:0]            end_wide;
   logic [VALUE_W-1:0]     limit;

   // The parser advances only when the result register can take a result.
   assign take     = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_pop = take;

   // Next state: walk the phases that this character passes through.
   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      minus_in   = minus_ff;
      ovf_in     = ovf_ff;
      dseen_in   = dseen_ff;
      base_in    = base_ff;
      pos_in     = pos_ff;
      bad_base   = 1'b0;
      do_finish  = 1'b0;
      finish_end = '0;
      mac        = '0;

      if (item.start) begin
         acc_in   = '0;
         minus_in = 1'b0;
         ovf_in   = 1'b0;
         dseen_in = 1'b0;
         base_in  = number_base;
         pos_in   = '0;
         if (number_base == 6'd1 || number_base > MAX_BASE) begin
            bad_base = 1'b1;
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_SPACE;
         end
      end

      // Phases that do not consume the character hand it on to the next one.
      if (!bad_base) begin
         if (phase_in == PH_SPACE && !item.blank && !item.plus && !item.minus) begin
            phase_in = PH_SIGNED;
         end
         if (phase_in == PH_SIGNED &&
             !((base_in == 6'd0 || base_in == 6'd16) && item.zero)) begin
            if (base_in == 6'd0) begin
               base_in = 6'd10;
            end
            phase_in = PH_DIGITS;
         end
         if (phase_in == PH_ZERO && !item.letter_x) begin
            if (base_in == 6'd0) begin
               base_in = 6'd8;
            end
            phase_in = PH_DIGITS;
         end
         if (phase_in == PH_ZERO_X && item.digit_ok && item.digit_val < 6'd16) begin
            base_in  = 6'd16;
            phase_in = PH_DIGITS;
         end

         mac = (VALUE_W + BASE_W)'(acc_in) * (VALUE_W + BASE_W)'(base_in)
             + (VALUE_W + BASE_W)'(item.digit_val);

         case (phase_in)
            PH_SPACE: begin
               if (item.plus || item.minus) begin
                  minus_in = item.minus;
                  phase_in = PH_SIGNED;
               end
               if (64'(pos_in) < MAX_OFFSET) begin
                  pos_in = pos_in + 1'b1;
               end
            end
            PH_SIGNED: begin
               dseen_in = 1'b1;
               phase_in = PH_ZERO;
               if (64'(pos_in) < MAX_OFFSET) begin
                  pos_in = pos_in + 1'b1;
               end
            end
            PH_ZERO: begin
               phase_in = PH_ZERO_X;
               if (64'(pos_in) < MAX_OFFSET) begin
                  pos_in = pos_in + 1'b1;
               end
            end
            PH_ZERO_X: begin
               // A prefix without a hex digit after it: the number is the lone zero.
               do_finish  = 1'b1;
               finish_end = (pos_in != '0) ? pos_in - 1'b1 : '0;
               phase_in   = PH_DONE;
            end
            PH_DIGITS: begin
               if (item.digit_ok && item.digit_val < base_in) begin
                  dseen_in = 1'b1;
                  if (mac[VALUE_W+BASE_W-1:VALUE_W] != '0) begin
                     ovf_in = 1'b1;
                  end else if (!ovf_in) begin
                     acc_in = mac[VALUE_W-1:0];
                  end
                  if (64'(pos_in) < MAX_OFFSET) begin
                     pos_in = pos_in + 1'b1;
                  end
               end else begin
                  do_finish  = 1'b1;
                  finish_end = pos_in;
                  phase_in   = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Outputs: format the result and manage the result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      offset_in    = offset_ff;
      status_in    = status_ff;
      end_wide     = 64'(finish_end);
      limit        = minus_in ? SIGNED_MIN : SIGNED_MAX;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take && bad_base) begin
         rsp_valid_in = 1'b1;
         value_in     = '0;
         offset_in    = '0;
         status_in    = ST_BAD_BASE;
      end else if (take && do_finish) begin
         rsp_valid_in = 1'b1;
         offset_in    = (end_wide > 64'hffff) ? 16'hffff : end_wide[OFFSET_W-1:0];
         status_in    = ST_OK;
         if (!dseen_in) begin
            value_in  = '0;
            offset_in = '0;
            status_in = ST_NO_DIGITS;
         end else if (signed_mode) begin
            if (ovf_in || acc_in > limit) begin
               value_in  = limit;
               status_in = ST_OVERFLOW;
            end else begin
               value_in = minus_in ? VALUE_W'(0) - acc_in : acc_in;
            end
         end else if (ovf_in) begin
            value_in  = UNSIGNED_MAX;
            status_in = ST_OVERFLOW;
         end else begin
            value_in = minus_in ? VALUE_W'(0) - acc_in : acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         minus_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         dseen_ff     <= 1'b0;
         base_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            minus_ff <= minus_in;
            ovf_ff   <= ovf_in;
            dseen_ff <= dseen_in;
            base_ff  <= base_in;
            pos_ff   <= pos_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      offset_ff <= offset_in;
      status_ff <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = value_ff;
   assign rsp_end_offset   = offset_ff;
   assign rsp_parse_status = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      (take && item.start && (number_base == 6'd1 || number_base > MAX_BASE))
      |=> (rsp_valid_ff && status_ff == ST_BAD_BASE))
      else $error("invalid base did not give its result");

   assert property (@(posedge clock) disable iff (reset)
      (take && item.start) |=> (phase_ff != PH_IDLE))
      else $error("string start left the parser idle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_NO_DIGITS) |-> (value_ff == '0 && offset_ff == '0))
      else $error("no-digit result carries a value or offset");

endmodule

[rtl/wide_text_to_integer.sv]
`timescale 1ns / 1ps
// Top level of the streaming wide text to integer parser.
//
// Usage: characters enter on the req_ channel, one 16-bit character per item,
// with req_string_start set on the first character of each string. The parser
// skips white space, takes an optional sign and an optional 0x prefix, and
// accumulates digits in the configured radix. The first character that is not
// a digit (the zero terminator included) ends the number and gives one item on
// the rsp_ channel with the value, the end offset and a status. Characters of a
// string that has finished, or that arrive before any string start, give none.
// The csr_ channel writes number_base (index 0) and signed_mode (index 1); it is
// always ready. The user must write it only while the parser is idle; the block
// does not enforce this. A character is accepted into a four-entry queue,
// classified on the way in, and taken by the parser from the queue head. The
// parser takes one character per cycle with its single multiply-accumulate,
// while the result register can take a result. When rsp_ready is low, the
// result register holds its item, the parser stops and the queue absorbs up to
// four more characters before req_ready falls. Reset empties the queue, drops
// any pending result, idles the parser and restores base 10 and signed mode.
module wide_text_to_integer #(
   parameter longint unsigned MAX_OFFSET = 65535
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wtti_pkg::CHAR_W-1:0]           req_wide_char,
   input  logic                                  req_string_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wtti_pkg::VALUE_W-1:0]          rsp_parsed_value,
   output logic [wtti_pkg::OFFSET_W-1:0]         rsp_end_offset,
   output logic [wtti_pkg::STATUS_W-1:0]         rsp_parse_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wtti_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wtti_pkg::CSR_DATA_W-1:0]       csr_data
);
   import wtti_pkg::*;

   logic [BASE_W-1:0]  number_base_ff, number_base_in;
   logic               signed_mode_ff, signed_mode_in;

   logic               queue_full;
   logic               queue_not_empty;
   logic               push;
   logic               pop;
   item_class_type     push_item;
   item_class_type     head_item;

   assign csr_ready = 1'b1;

   always_comb begin
      number_base_in = number_base_ff;
      signed_mode_in = signed_mode_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_NUMBER_BASE: number_base_in = csr_data[BASE_W-1:0];
            CSR_SIGNED_MODE: signed_mode_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= 6'd10;
         signed_mode_ff <= 1'b1;
      end else begin
         number_base_ff <= number_base_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   wtti_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_wide_char    (req_wide_char),
      .req_string_start (req_string_start),
      .queue_full       (queue_full),
      .push             (push),
      .push_item        (push_item)
   );

   wtti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   wtti_back #(
      .MAX_OFFSET (MAX_OFFSET)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (queue_not_empty),
      .item             (head_item),
      .item_pop         (pop),
      .number_base      (number_base_ff),
      .signed_mode      (signed_mode_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_parse_status (rsp_parse_status)
   );

endmodule

[dv/wide_text_to_integer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the wide text to integer parser, with its own number predictor.
module wide_text_to_integer_tb;

   import wtti_pkg::*;

   localparam int          TEXT_POS_MAX = 65535;
   localparam int          RANDOM_ITEMS = 1320;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          SCRIPT_ROWS  = 31;
   localparam longint      TIMEOUT_NS   = 64'd40_000_000;

   localparam logic [15:0] CH_NUL     = 16'h0000;
   localparam logic [15:0] CH_SPACE   = 16'h0020;
   localparam logic [15:0] CH_PLUS    = 16'h002b;
   localparam logic [15:0] CH_MINUS   = 16'h002d;
   localparam logic [15:0] CH_ZERO    = 16'h0030;
   localparam logic [15:0] CH_X_UPPER = 16'h0058;
   localparam logic [15:0] CH_X_LOWER = 16'h0078;
   localparam logic [6:0]  NOT_DIGIT  = 7'h7f;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [OFFSET_W-1:0] offset;
      logic [STATUS_W-1:0] status;
   } parse_result_type;

   typedef enum logic {ROW_CHAR, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [15:0]      arg;
      logic             start;
      csr_index_type    idx;
      logic             typed;
      parse_result_type want;
   } script_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_type;

   localparam parse_result_type NO_NUM  = '0;
   localparam parse_result_type BAD_NUM = '{value: '0, offset: '0, status: ST_BAD_BASE};

   // Rows with a typed result are checked against that result; the rest go to the predictor.
   localparam script_row_type DIRECTED_SCRIPT [SCRIPT_ROWS] = '{
      '{ROW_CHAR, 16'h0020, 1'b1, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h002d, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0039, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0000, 1'b0, CSR_NUMBER_BASE, 1'b1,
        '{value: 32'hffff_fff7, offset: 16'd3, status: ST_OK}},
      '{ROW_CHAR, 16'h0035, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0000, 1'b1, CSR_NUMBER_BASE, 1'b1,
        '{value: 32'd0, offset: 16'd0, status: ST_NO_DIGITS}},
      '{ROW_CSR,  16'd0,    1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0030, 1'b1, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0078, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0066, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0000, 1'b0, CSR_NUMBER_BASE, 1'b1,
        '{value: 32'd15, offset: 16'd3, status: ST_OK}},
      '{ROW_CHAR, 16'h0030, 1'b1, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0058, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0067, 1'b0, CSR_NUMBER_BASE, 1'b1,
        '{value: 32'd0, offset: 16'd1, status: ST_OK}},
      '{ROW_CHAR, 16'h002b, 1'b1, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0030, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0037, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0039, 1'b0, CSR_NUMBER_BASE, 1'b1,
        '{value: 32'd7, offset: 16'd3, status: ST_OK}},
      '{ROW_CSR,  16'd1,    1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h0061, 1'b1, CSR_NUMBER_BASE, 1'b1, BAD_NUM},
      '{ROW_CSR,  16'd63,   1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'hffff, 1'b1, CSR_NUMBER_BASE, 1'b1, BAD_NUM},
      '{ROW_CSR,  16'd36,   1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h005a, 1'b1, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h007a, 1'b1, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h007a, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h007a, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h007a, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h007a, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'h007a, 1'b0, CSR_NUMBER_BASE, 1'b0, NO_NUM},
      '{ROW_CHAR, 16'hffff, 1'b0, CSR_NUMBER_BASE, 1'b1,
        '{value: SIGNED_MAX, offset: 16'd6, status: ST_OVERFLOW}}
   };

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [CHAR_W-1:0]        req_wide_char    = '0;
   logic                     req_string_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b1;
   logic [VALUE_W-1:0]       rsp_parsed_value;
   logic [OFFSET_W-1:0]      rsp_end_offset;
   logic [STATUS_W-1:0]      rsp_parse_status;
   logic                     csr_valid        = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index        = '0;
   logic [CSR_DATA_W-1:0]    csr_data         = '0;

   // Predictor copy of the registers and of the parse state.
   logic [BASE_W-1:0]        cfg_base   = 6'd10;
   logic                     cfg_signed = 1'b1;
   parse_phase_type          phase_q    = PH_IDLE;
   logic [VALUE_W-1:0]       acc_q      = '0;
   logic                     minus_q    = 1'b0;
   logic                     ovf_q      = 1'b0;
   logic                     digit_q    = 1'b0;
   logic [BASE_W-1:0]        base_q     = '0;
   logic [OFFSET_W-1:0]      pos_q      = '0;

   parse_result_type         pending_numbers [$];
   parse_result_type         head;
   int                       mismatch_count = 0;
   int                       counted_items  = 0;
   int                       burst_left     = 0;
   rx_mode_type              rx_mode        = RX_OPEN;
   int                       rx_left        = 0;

   wide_text_to_integer #(
      .MAX_OFFSET(TEXT_POS_MAX)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_wide_char    (req_wide_char),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_parse_status (rsp_parse_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] digit_value(input logic [15:0] ch);
      if (ch >= 16'd48 && ch <= 16'd57) return 7'(ch - 16'd48);
      if (ch >= 16'd97 && ch <= 16'd122) return 7'(ch - 16'd87);
      if (ch >= 16'd65 && ch <= 16'd90) return 7'(ch - 16'd55);
      return NOT_DIGIT;
   endfunction

   function automatic void advance_pos();
      if (32'(pos_q) < TEXT_POS_MAX) pos_q = pos_q + 16'd1;
   endfunction

   function automatic parse_result_type close_number(input logic [15:0] stop);
      parse_result_type   r;
      logic [VALUE_W-1:0] limit;
      phase_q = PH_DONE;
      r = '{value: '0, offset: stop, status: ST_OK};
      if (!digit_q) begin
         r.offset = '0;
         r.status = ST_NO_DIGITS;
      end else if (cfg_signed) begin
         limit = minus_q ? SIGNED_MIN : SIGNED_MAX;
         if (ovf_q || acc_q > limit) begin
            r.value  = limit;
            r.status = ST_OVERFLOW;
         end else begin
            r.value = minus_q ? 32'd0 - acc_q : acc_q;
         end
      end else if (ovf_q) begin
         r.value  = UNSIGNED_MAX;
         r.status = ST_OVERFLOW;
      end else begin
         r.value = minus_q ? 32'd0 - acc_q : acc_q;
      end
      return r;
   endfunction

   // Advances the parse by one character; returns 1 when the character gives a result.
   function automatic bit parse_char(input logic [15:0] ch, input logic st,
                                     output parse_result_type res);
      logic [6:0]         dval;
      logic [VALUE_W-1:0] headroom;
      res     = NO_NUM;
      dval    = digit_value(ch);
      if (st) begin
         acc_q   = '0;
         minus_q = 1'b0;
         ovf_q   = 1'b0;
         digit_q = 1'b0;
         base_q  = cfg_base;
         pos_q   = '0;
         if (base_q == 6'd1 || base_q > MAX_BASE) begin
            res     = BAD_NUM;
            phase_q = PH_DONE;
            return 1'b1;
         end
         phase_q = PH_SPACE;
      end else if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
         return 1'b0;
      end
      if (phase_q == PH_SPACE) begin
         if (ch == CH_SPACE || (ch >= 16'd9 && ch <= 16'd13)) begin
            advance_pos();
            return 1'b0;
         end
         phase_q = PH_SIGNED;
         if (ch == CH_PLUS || ch == CH_MINUS) begin
            minus_q = (ch == CH_MINUS);
            advance_pos();
            return 1'b0;
         end
      end
      if (phase_q == PH_SIGNED) begin
         if ((base_q == 6'd0 || base_q == 6'd16) && ch == CH_ZERO) begin
            digit_q = 1'b1;
            advance_pos();
            phase_q = PH_ZERO;
            return 1'b0;
         end
         if (base_q == 6'd0) base_q = 6'd10;
         phase_q = PH_DIGITS;
      end
      if (phase_q == PH_ZERO) begin
         if (ch == CH_X_LOWER || ch == CH_X_UPPER) begin
            advance_pos();
            phase_q = PH_ZERO_X;
            return 1'b0;
         end
         if (base_q == 6'd0) base_q = 6'd8;
         phase_q = PH_DIGITS;
      end
      if (phase_q == PH_ZERO_X) begin
         // The prefix only counts when a hex digit follows; otherwise the number is the lone 0.
         if (dval >= 7'd16) begin
            res = close_number(pos_q != 16'd0 ? pos_q - 16'd1 : 16'd0);
            return 1'b1;
         end
         base_q  = 6'd16;
         phase_q = PH_DIGITS;
      end
      if (phase_q == PH_DIGITS) begin
         if (dval < {1'b0, base_q}) begin
            digit_q  = 1'b1;
            headroom = (UNSIGNED_MAX - 32'(dval)) / 32'(base_q);
            if (acc_q > headroom) ovf_q = 1'b1;
            else if (!ovf_q) acc_q = acc_q * 32'(base_q) + 32'(dval);
            advance_pos();
            return 1'b0;
         end
         res = close_number(pos_q);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_numbers.size() == 0) begin
            report_mismatch("unexpected result", rsp_parsed_value, 32'd0);
         end else begin
            head = pending_numbers.pop_front();
            if (rsp_parsed_value !== head.value)
               report_mismatch("parsed_value", rsp_parsed_value, head.value);
            if (rsp_end_offset !== head.offset)
               report_mismatch("end_offset", 32'(rsp_end_offset), 32'(head.offset));
            if (rsp_parse_status !== head.status)
               report_mismatch("parse_status", 32'(rsp_parse_status), 32'(head.status));
         end
      end
   end

   // The receiver switches between open, choppy and mostly stalled stretches.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(16, 80);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_CHOPPY: rsp_ready <= ($urandom_range(0, 1) == 1);
         default:   rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_char(input logic [15:0] ch, input logic st, input bit use_typed,
                            input parse_result_type typed_want);
      int               gap;
      parse_result_type got;
      bit               produced;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_wide_char    <= ch;
      req_string_start <= st;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = parse_char(ch, st, got);
      if (use_typed) pending_numbers.push_back(typed_want);
      else if (produced) pending_numbers.push_back(got);
      counted_items++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [5:0] data, input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_NUMBER_BASE) cfg_base = data;
      else cfg_signed = data[0];
      @(negedge clock);
      if (!more) csr_valid <= 1'b0;
   endtask

   // Lets every pending number come out and the parser run dry before the next step.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_numbers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [15:0] blank_char();
      return ($urandom_range(0, 5) == 0) ? CH_SPACE : 16'(8 + $urandom_range(1, 5));
   endfunction

   function automatic logic [15:0] digit_char(input int d);
      if (d < 10) return 16'(48 + d);
      return 16'((($urandom_range(0, 1) == 1) ? 97 : 65) + d - 10);
   endfunction

   // One string: optional blanks, sign, prefix, digits of a chosen amount and ending character.
   task automatic send_random_text();
      logic [15:0] text [$];
      logic [63:0] amount;
      int          radix;
      int          first;
      text  = {};
      radix = int'(cfg_base);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) text.push_back(blank_char());
      case ($urandom_range(0, 2))
         1:       text.push_back(CH_PLUS);
         2:       text.push_back(CH_MINUS);
         default: ;
      endcase
      if (cfg_base == 6'd0 || cfg_base == 6'd16) begin
         case ($urandom_range(0, 3))
            0: begin
               text.push_back(CH_ZERO);
               text.push_back(($urandom_range(0, 1) == 1) ? CH_X_LOWER : CH_X_UPPER);
               radix = 16;
            end
            1: begin
               if (cfg_base == 6'd0) begin
                  text.push_back(CH_ZERO);
                  radix = 8;
               end
            end
            default: ;
         endcase
      end
      if (radix < 2 || radix > 36) radix = 10;
      if ($urandom_range(0, 9) != 0) begin
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
               0:       amount = 64'h7fff_ffff;
               1:       amount = 64'h8000_0000;
               2:       amount = 64'hffff_ffff;
               default: amount = 64'h1_0000_0000;
            endcase
            amount = amount + 64'($urandom_range(0, 2)) - 64'd1;
         end else begin
            case ($urandom_range(0, 2))
               0:       amount = 64'($urandom_range(0, 999));
               1:       amount = 64'($urandom);
               default: amount = {$urandom, $urandom};
            endcase
         end
         first = text.size();
         do begin
            text.insert(first, digit_char(int'(amount % 64'(radix))));
            amount = amount / 64'(radix);
         end while (amount != 64'd0);
      end
      // Without an ending character the next string start abandons this one.
      case ($urandom_range(0, 5))
         0, 1:    text.push_back(CH_NUL);
         2, 3:    text.push_back(16'($urandom));
         4:       text.push_back(16'($urandom_range(33, 126)));
         default: ;
      endcase
      if (text.size() == 0) text.push_back(CH_NUL);
      foreach (text[i]) send_char(text[i], i == 0, 1'b0, NO_NUM);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_char(16'($urandom), 1'b0, 1'b0, NO_NUM);
   endtask

   initial begin
      script_row_type row;
      logic [5:0]     pick_base;
      int             random_start;
      int             phase_end;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         row = DIRECTED_SCRIPT[i];
         if (row.kind == ROW_CSR) begin
            if (i == 0 || DIRECTED_SCRIPT[i-1].kind != ROW_CSR) wait_for_idle();
            write_csr(row.idx, row.arg[5:0],
                      i + 1 < SCRIPT_ROWS && DIRECTED_SCRIPT[i+1].kind == ROW_CSR);
         end else begin
            send_char(row.arg, row.start, row.typed, row.want);
         end
      end

      random_start = counted_items;
      while (counted_items - random_start < RANDOM_ITEMS) begin
         wait_for_idle();
         case ($urandom_range(0, 11))
            0, 1:    pick_base = 6'd0;
            2:       pick_base = 6'd2;
            3:       pick_base = MAX_BASE;
            4:       pick_base = 6'd8;
            5, 6:    pick_base = 6'd16;
            7:       pick_base = 6'd10;
            8, 9:    pick_base = 6'($urandom_range(2, 36));
            10:      pick_base = 6'd1;
            default: pick_base = 6'($urandom_range(37, 63));
         endcase
         write_csr(CSR_NUMBER_BASE, pick_base, 1'b1);
         write_csr(CSR_SIGNED_MODE, 6'($urandom_range(0, 63)), 1'b0);
         phase_end = counted_items + ((pick_base == 6'd1 || pick_base > MAX_BASE) ? 30 : 170);
         while (counted_items < phase_end) send_random_text();
         send_char(CH_NUL, 1'b0, 1'b0, NO_NUM);
      end
      wait_for_idle();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
